/* design/hjo_pkg.sv */
// ----------------------------------------------------------------------------
// hjo_pkg
// Shared types and constants for the Halton jitter offset generator.
// ----------------------------------------------------------------------------
package hjo_pkg;

    localparam int PHASE_W     = 8;
    localparam int INDEX_W     = 31;
    localparam int IDX_PAD_W   = 32;
    localparam int OUT_W       = 16;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 32;
    localparam int RADIX_BITS  = 4;
    localparam int MOD_STEPS   = IDX_PAD_W / RADIX_BITS;
    localparam int DEN_W       = 10;
    localparam int DIGIT_W     = 2;
    localparam int RECIP3      = 171;
    localparam int RECIP3_SHIFT = 9;

    localparam logic [PHASE_W-1:0] PHASE_COUNT_RESET = 8'd8;
    localparam int FRAC_BITS_DEFAULT       = 16;
    localparam int MAX_PHASE_COUNT_DEFAULT = 255;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic dig_init;
        logic dig_step;
        logic div_init;
        logic div_step;
        logic res_load;
    } hjo_cmd_t;

    typedef struct packed {
        logic dig_last;
    } hjo_sts_t;

    function automatic int div_steps(input int frac_bits);
        return (frac_bits + RADIX_BITS - 1) / RADIX_BITS;
    endfunction

endpackage

/* design/hjo_datapath.sv */
// ----------------------------------------------------------------------------
// hjo_datapath
// Phase register, index remainder, base-3 digit reversal, fraction divider
// and result registers.
// ----------------------------------------------------------------------------
module hjo_datapath #(
    parameter int FRAC_BITS       = hjo_pkg::FRAC_BITS_DEFAULT,
    parameter int MAX_PHASE_COUNT = hjo_pkg::MAX_PHASE_COUNT_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [hjo_pkg::PHASE_W-1:0]   cfg_wdata,
    input  logic [hjo_pkg::INDEX_W-1:0]   frame_index,
    input  hjo_pkg::hjo_cmd_t             cmd,
    output hjo_pkg::hjo_sts_t             sts,
    output logic [hjo_pkg::OUT_W-1:0]     jitter_x,
    output logic [hjo_pkg::OUT_W-1:0]     jitter_y
);

    localparam int PW       = hjo_pkg::PHASE_W;
    localparam int IW       = hjo_pkg::IDX_PAD_W;
    localparam int DW       = hjo_pkg::DEN_W;
    localparam int RB       = hjo_pkg::RADIX_BITS;
    localparam int OW       = hjo_pkg::OUT_W;
    localparam int DIV_STEPS = hjo_pkg::div_steps(FRAC_BITS);
    localparam int QUO_W    = DIV_STEPS * RB;
    localparam int EXT_W    = FRAC_BITS + OW;
    localparam int CLAMP_W  = 16;
    localparam int RECIP_W  = 9;
    localparam int PROD_W   = PW + RECIP_W;
    localparam logic [EXT_W-1:0] HALF = EXT_W'(1) << (FRAC_BITS - 1);

    logic [PW-1:0]        phase_count_reg;
    logic [PW-1:0]        pc_reg;
    logic [PW-1:0]        pc_eff;
    logic [IW-1:0]        idx_reg;
    logic [IW-1:0]        idx_step;
    logic [PW-1:0]        rem_reg;
    logic [PW-1:0]        rem_step;
    logic [PW-1:0]        nval_reg;
    logic [PW-1:0]        n_first;
    logic [FRAC_BITS-1:0] hx_reg;
    logic [FRAC_BITS-1:0] hx_next;
    logic [DW-1:0]        rev_reg;
    logic [DW-1:0]        den_reg;
    logic [DW-1:0]        rr_reg;
    logic [DW-1:0]        rr_step;
    logic [QUO_W-1:0]     quo_reg;
    logic [QUO_W-1:0]     quo_step;
    logic [PROD_W-1:0]    prod3;
    logic [PW-1:0]        q3;
    logic [PW:0]          three_q;
    logic [PW:0]          n_minus;
    logic [hjo_pkg::DIGIT_W-1:0] digit;
    logic [DW+1:0]        rev_x3;
    logic [DW+1:0]        den_x3;
    logic [PW:0]          mod_t;
    logic [PW-1:0]        mod_r;
    logic [IW-1:0]        mod_i;
    logic [DW:0]          div_t;
    logic [DW-1:0]        div_r;
    logic [QUO_W-1:0]     div_q;
    logic [EXT_W-1:0]     diff_x;
    logic [EXT_W-1:0]     diff_y;
    logic [OW-1:0]        jitter_x_reg;
    logic [OW-1:0]        jitter_y_reg;

    // zero phase count acts as one, large values saturate
    always_comb begin
        pc_eff = phase_count_reg;
        if (phase_count_reg == '0) begin
            pc_eff = PW'(1);
        end else if (CLAMP_W'(phase_count_reg) > CLAMP_W'(MAX_PHASE_COUNT)) begin
            pc_eff = PW'(MAX_PHASE_COUNT);
        end
    end

    // remainder, several bits of the index per cycle
    always_comb begin
        mod_r = rem_reg;
        mod_i = idx_reg;
        mod_t = '0;
        for (int j = 0; j < RB; j++) begin
            mod_t = {mod_r, mod_i[IW-1]};
            mod_i = {mod_i[IW-2:0], 1'b0};
            if (mod_t >= {1'b0, pc_reg}) begin
                mod_t = mod_t - {1'b0, pc_reg};
            end
            mod_r = mod_t[PW-1:0];
        end
        rem_step = mod_r;
        idx_step = mod_i;
    end

    assign n_first = rem_reg + PW'(1);

    // base-2 mirror needs no loop: digit i lands at weight 2^-(i+1)
    always_comb begin
        hx_next = '0;
        for (int i = 0; i < PW; i++) begin
            hx_next[FRAC_BITS-1-i] = n_first[i];
        end
    end

    // divide by three through the reciprocal, exact for 8-bit values
    assign prod3   = PROD_W'(nval_reg) * PROD_W'(hjo_pkg::RECIP3);
    assign q3      = prod3[hjo_pkg::RECIP3_SHIFT +: PW];
    assign three_q = {q3, 1'b0} + {1'b0, q3};
    assign n_minus = {1'b0, nval_reg} - three_q;
    assign digit   = n_minus[hjo_pkg::DIGIT_W-1:0];
    assign rev_x3  = {1'b0, rev_reg, 1'b0} + {2'b00, rev_reg} + (DW+2)'(digit);
    assign den_x3  = {1'b0, den_reg, 1'b0} + {2'b00, den_reg};
    assign sts.dig_last = (q3 == '0);

    // restoring division of rev by den, several quotient bits per cycle
    always_comb begin
        div_r = rr_reg;
        div_q = quo_reg;
        div_t = '0;
        for (int j = 0; j < RB; j++) begin
            div_t = {div_r, 1'b0};
            if (div_t >= {1'b0, den_reg}) begin
                div_t = div_t - {1'b0, den_reg};
                div_q = {div_q[QUO_W-2:0], 1'b1};
            end else begin
                div_q = {div_q[QUO_W-2:0], 1'b0};
            end
            div_r = div_t[DW-1:0];
        end
        rr_step  = div_r;
        quo_step = div_q;
    end

    assign diff_x = EXT_W'(hx_reg) - HALF;
    assign diff_y = EXT_W'(quo_reg[QUO_W-1 -: FRAC_BITS]) - HALF;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_count_reg <= hjo_pkg::PHASE_COUNT_RESET;
        end else if (cfg_we) begin
            phase_count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            idx_reg <= {1'b0, frame_index};
            rem_reg <= '0;
            pc_reg  <= pc_eff;
        end else if (cmd.mod_step) begin
            idx_reg <= idx_step;
            rem_reg <= rem_step;
        end
        if (cmd.dig_init) begin
            nval_reg <= n_first;
            hx_reg   <= hx_next;
            rev_reg  <= '0;
            den_reg  <= DW'(1);
        end else if (cmd.dig_step) begin
            nval_reg <= q3;
            rev_reg  <= rev_x3[DW-1:0];
            den_reg  <= den_x3[DW-1:0];
        end
        if (cmd.div_init) begin
            rr_reg  <= rev_reg;
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            rr_reg  <= rr_step;
            quo_reg <= quo_step;
        end
        if (cmd.res_load) begin
            jitter_x_reg <= diff_x[OW-1:0];
            jitter_y_reg <= diff_y[OW-1:0];
        end
    end

    assign jitter_x = jitter_x_reg;
    assign jitter_y = jitter_y_reg;

endmodule

/* design/hjo_ctrl.sv */
// ----------------------------------------------------------------------------
// hjo_ctrl
// Sequencer for remainder, digit and division phases, and the output
// valid flag.
// ----------------------------------------------------------------------------
module hjo_ctrl #(
    parameter int FRAC_BITS = hjo_pkg::FRAC_BITS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  hjo_pkg::hjo_sts_t sts,
    output hjo_pkg::hjo_cmd_t cmd
);

    localparam int DIV_STEPS = hjo_pkg::div_steps(FRAC_BITS);
    localparam int MAX_STEPS = (hjo_pkg::MOD_STEPS > DIV_STEPS) ?
                               hjo_pkg::MOD_STEPS : DIV_STEPS;
    localparam int CNT_W     = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_PREP,
        ST_DIGIT,
        ST_DIVPREP,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t         state_reg;
    state_t         state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic           m_tvalid_reg;
    logic           m_tvalid_next;
    logic           out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                cmd.mod_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(hjo_pkg::MOD_STEPS - 1)) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.dig_init = 1'b1;
                state_next   = ST_DIGIT;
            end
            ST_DIGIT: begin
                cmd.dig_step = 1'b1;
                if (sts.dig_last) begin
                    state_next = ST_DIVPREP;
                end
            end
            ST_DIVPREP: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait for the previous transaction to leave the output register
                if (out_free) begin
                    cmd.res_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

/* design/halton_jitter_offset.sv */
// Each input transaction runs the 4-bit-per-cycle remainder loop over the index,
// then the digit loop over the k (1..6) base-3 digits of the remainder plus one,
// then the 4-bit-per-cycle divider; s_tready is high only while the sequencer is
// idle, so a new item is taken only after the last result is loaded for output.
// Reset: synchronous active-low aresetn; phase count returns to 8, no output pending.
// ----------------------------------------------------------------------------
// halton_jitter_offset
// Base-2 / base-3 Halton subpixel jitter pair in signed fixed point.
// ----------------------------------------------------------------------------
module halton_jitter_offset #(
    parameter int FRAC_BITS       = hjo_pkg::FRAC_BITS_DEFAULT,
    parameter int MAX_PHASE_COUNT = hjo_pkg::MAX_PHASE_COUNT_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [hjo_pkg::PHASE_W-1:0]    cfg_wdata,    // phase_count
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hjo_pkg::S_TDATA_W-1:0]  s_tdata,      // [30:0] frame_index
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hjo_pkg::M_TDATA_W-1:0]  m_tdata       // [15:0] jitter_x, [31:16] jitter_y
);

    hjo_pkg::hjo_cmd_t          cmd;
    hjo_pkg::hjo_sts_t          sts;
    logic [hjo_pkg::OUT_W-1:0]  jitter_x;
    logic [hjo_pkg::OUT_W-1:0]  jitter_y;

    hjo_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hjo_datapath #(
        .FRAC_BITS       (FRAC_BITS),
        .MAX_PHASE_COUNT (MAX_PHASE_COUNT)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .frame_index (s_tdata[hjo_pkg::INDEX_W-1:0]),
        .cmd         (cmd),
        .sts         (sts),
        .jitter_x    (jitter_x),
        .jitter_y    (jitter_y)
    );

    assign m_tdata = {jitter_y, jitter_x};

endmodule
